@@ src/depth_layer_velocity_interpolator_top_defines.svh @@
// assertion macros shared by the interpolator checker
`ifndef DEPTH_LAYER_VELOCITY_INTERPOLATOR_TOP_DEFINES_SVH
`define DEPTH_LAYER_VELOCITY_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DLVI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DLVI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dlvi_pkg.sv @@
// shared types, widths and helpers for the depth layer velocity interpolator
`default_nettype none

package dlvi_pkg;

  // table size and derived widths
  localparam int MAX_LAYERS = 16;
  localparam int ADDR_W     = $clog2(MAX_LAYERS);
  localparam int CNT_W      = $clog2(MAX_LAYERS + 1);

  // field widths fixed by the interface
  localparam int SLOT_W  = 4;
  localparam int DEPTH_W = 18;
  localparam int VEL_W   = 16;
  localparam int POS_W   = 19;
  localparam int USED_W  = 19;
  localparam int CFG_W   = 5;

  // divider: quotient never exceeds the velocity span
  localparam int QBITS  = VEL_W;
  localparam int QCNT_W = $clog2(QBITS);
  localparam int PROD_W = VEL_W + DEPTH_W;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    AXIS_EAST  = 2'd0,
    AXIS_NORTH = 2'd1,
    AXIS_UP    = 2'd2
  } axis_t;

  // one table entry as stored in the layer ram
  typedef struct packed {
    logic        [DEPTH_W-1:0] depth;
    logic signed [VEL_W-1:0]   east;
    logic signed [VEL_W-1:0]   north;
    logic signed [VEL_W-1:0]   up;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic  start;
    logic  empty;
    logic  cap_lo;
    logic  cap_hi;
    logic  res_from_q;
    logic  prep;
    logic  mul;
    logic  div;
    logic  fix;
    logic  load_out;
    axis_t axis;
  } dlvi_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic le_q;
    logic ge_q;
  } dlvi_sts_t;

  // pick one velocity component of an entry
  function automatic logic signed [VEL_W-1:0] get_vel(entry_t e, axis_t a);
    logic signed [VEL_W-1:0] v;
    unique case (a)
      AXIS_EAST:  v = e.east;
      AXIS_NORTH: v = e.north;
      AXIS_UP:    v = e.up;
      default:    v = e.up;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/dlvi_in_if.sv @@
// request channel: load items and queries
`default_nettype none

interface dlvi_in_if import dlvi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic        [SLOT_W-1:0]  entry_slot;
  logic        [DEPTH_W-1:0] entry_depth_cm;
  logic signed [VEL_W-1:0]   entry_vel_east;
  logic signed [VEL_W-1:0]   entry_vel_north;
  logic signed [VEL_W-1:0]   entry_vel_up;
  logic signed [POS_W-1:0]   vertical_position_cm;

  modport source (
    output valid, req_type, entry_slot, entry_depth_cm, entry_vel_east,
           entry_vel_north, entry_vel_up, vertical_position_cm,
    input  ready
  );

  modport sink (
    input  valid, req_type, entry_slot, entry_depth_cm, entry_vel_east,
           entry_vel_north, entry_vel_up, vertical_position_cm,
    output ready
  );
endinterface

`default_nettype wire

@@ src/dlvi_out_if.sv @@
// result channel: interpolated velocity per query
`default_nettype none

interface dlvi_out_if import dlvi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0]  current_east;
  logic signed [VEL_W-1:0]  current_north;
  logic signed [VEL_W-1:0]  current_up;
  logic        [USED_W-1:0] depth_used_cm;
  logic                    no_data;

  modport source (
    output valid, current_east, current_north, current_up, depth_used_cm, no_data,
    input  ready
  );

  modport sink (
    input  valid, current_east, current_north, current_up, depth_used_cm, no_data,
    output ready
  );
endinterface

`default_nettype wire

@@ src/dlvi_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none

module dlvi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ src/dlvi_ctrl.sv @@
// controller: request handshake, table walk and interpolation sequencing
`default_nettype none

module dlvi_ctrl import dlvi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_req_type,
  output logic                   in_ready,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              out_ready,
  output logic                   out_valid,
  input  wire dlvi_sts_t         sts,
  output dlvi_cmd_t              cmd,
  output logic      [ADDR_W-1:0] rd_addr
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_HEAD = 9'b000000010,
    S_TAIL = 9'b000000100,
    S_SCAN = 9'b000001000,
    S_PREP = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_FIX  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    layers_r, layers_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    n_sat;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [QCNT_W-1:0]   qcnt_r, qcnt_nxt;
  axis_t               axis_r, axis_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  // layer count saturated to the table size
  assign n_sat = (32'(layers_r) > MAX_LAYERS) ? CNT_W'(MAX_LAYERS) : CNT_W'(layers_r);

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // configuration register
  always_comb begin
    layers_nxt = layers_r;
    if (cfg_we) begin
      layers_nxt = cfg_wdata;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    qcnt_nxt      = qcnt_r;
    axis_nxt      = axis_r;
    rd_addr       = '0;
    cmd           = '0;
    cmd.axis      = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_req_type == REQ_QUERY) begin
          cmd.start = 1'b1;
          cmd.empty = (n_sat == '0);
          n_nxt     = n_sat;
          state_nxt = (n_sat == '0) ? S_OUT : S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.cap_lo = 1'b1;
        rd_addr    = ADDR_W'(n_r - CNT_W'(1));
        if (n_r == CNT_W'(1) || sts.le_q) begin
          cmd.res_from_q = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        rd_addr = ADDR_W'(1);
        if (sts.ge_q) begin
          cmd.res_from_q = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          idx_nxt   = ADDR_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = idx_r + ADDR_W'(1);
        if (sts.le_q) begin
          cmd.cap_hi = 1'b1;
          axis_nxt   = AXIS_EAST;
          state_nxt  = S_PREP;
        end else begin
          cmd.cap_lo = 1'b1;
          idx_nxt    = idx_r + ADDR_W'(1);
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        qcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div  = 1'b1;
        qcnt_nxt = qcnt_r + QCNT_W'(1);
        if (qcnt_r == QCNT_W'(QBITS - 1)) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix = 1'b1;
        unique case (axis_r)
          AXIS_EAST:  begin
            axis_nxt  = AXIS_NORTH;
            state_nxt = S_PREP;
          end
          AXIS_NORTH: begin
            axis_nxt  = AXIS_UP;
            state_nxt = S_PREP;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag of the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      layers_r    <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      qcnt_r      <= '0;
      axis_r      <= AXIS_EAST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      layers_r    <= layers_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      qcnt_r      <= qcnt_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/dlvi_dp.sv @@
// datapath: depth clamp, bracket registers, multiplier, restoring divider
`default_nettype none

module dlvi_dp import dlvi_pkg::*; (
  input  wire logic                     clk,
  input  wire dlvi_cmd_t                cmd,
  input  wire logic signed [POS_W-1:0]  vertical_position_cm,
  input  wire entry_t                   q,
  output dlvi_sts_t                     sts,
  output logic signed      [VEL_W-1:0]  current_east,
  output logic signed      [VEL_W-1:0]  current_north,
  output logic signed      [VEL_W-1:0]  current_up,
  output logic             [USED_W-1:0] depth_used_cm,
  output logic                          no_data
);

  logic        [USED_W-1:0]  depth_r;
  logic                      nodata_r;
  entry_t                    lo_r;
  entry_t                    hi_r;
  logic        [DEPTH_W-1:0] num_r;
  logic        [DEPTH_W-1:0] den_r;
  logic        [VEL_W-1:0]   mag_r;
  logic                      neg_r;
  logic        [DEPTH_W-1:0] rem_r;
  logic        [QBITS-1:0]   quo_r;
  logic signed [VEL_W-1:0]   res_r [3];
  logic signed [VEL_W-1:0]   out_e_r, out_n_r, out_u_r;
  logic        [USED_W-1:0]  out_depth_r;
  logic                      out_nodata_r;

  logic        [USED_W-1:0]  depth_clamped;
  logic signed [VEL_W:0]     diff;
  logic        [PROD_W-1:0]  prod;
  logic        [DEPTH_W:0]   trial;
  logic        [VEL_W-1:0]   step_q;
  logic signed [VEL_W-1:0]   v_lo;

  // height to depth, clamped at the surface
  assign depth_clamped = vertical_position_cm[POS_W-1]
                         ? USED_W'(~vertical_position_cm + 1'b1) : '0;

  // depth compare against the entry on the ram read port
  assign sts.le_q = (depth_r <= USED_W'(q.depth));
  assign sts.ge_q = (depth_r >= USED_W'(q.depth));

  // velocity span of the current axis
  assign v_lo = get_vel(lo_r, cmd.axis);
  assign diff = (VEL_W+1)'(get_vel(hi_r, cmd.axis)) - (VEL_W+1)'(v_lo);

  // product and one restoring division step
  assign prod   = PROD_W'(mag_r) * PROD_W'(num_r);
  assign trial  = {rem_r, quo_r[QBITS-1]} - {1'b0, den_r};
  assign step_q = neg_r ? VEL_W'(-quo_r) : VEL_W'(quo_r);

  always_ff @(posedge clk) begin
    // new query: clamp depth and clear the result
    if (cmd.start) begin
      depth_r  <= depth_clamped;
      nodata_r <= cmd.empty;
      res_r[0] <= '0;
      res_r[1] <= '0;
      res_r[2] <= '0;
    end
    // end entries return their velocity directly
    if (cmd.res_from_q) begin
      res_r[0] <= q.east;
      res_r[1] <= q.north;
      res_r[2] <= q.up;
    end
    // bracket registers
    if (cmd.cap_lo) begin
      lo_r <= q;
    end
    if (cmd.cap_hi) begin
      hi_r  <= q;
      num_r <= DEPTH_W'(depth_r - USED_W'(lo_r.depth));
      den_r <= q.depth - lo_r.depth;
    end
    // sign and magnitude of the span
    if (cmd.prep) begin
      neg_r <= diff[VEL_W];
      mag_r <= diff[VEL_W] ? VEL_W'(-diff) : VEL_W'(diff);
    end
    // quotient fits in QBITS, so the high part starts below the divisor
    if (cmd.mul) begin
      rem_r <= prod[PROD_W-1:QBITS];
      quo_r <= prod[QBITS-1:0];
    end
    if (cmd.div) begin
      if (!trial[DEPTH_W]) begin
        rem_r <= trial[DEPTH_W-1:0];
        quo_r <= {quo_r[QBITS-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DEPTH_W-2:0], quo_r[QBITS-1]};
        quo_r <= {quo_r[QBITS-2:0], 1'b0};
      end
    end
    // apply the truncated quotient to the lower velocity
    if (cmd.fix) begin
      res_r[cmd.axis] <= v_lo + step_q;
    end
    // output register
    if (cmd.load_out) begin
      out_e_r      <= res_r[0];
      out_n_r      <= res_r[1];
      out_u_r      <= res_r[2];
      out_depth_r  <= depth_r;
      out_nodata_r <= nodata_r;
    end
  end

  assign current_east  = out_e_r;
  assign current_north = out_n_r;
  assign current_up    = out_u_r;
  assign depth_used_cm = out_depth_r;
  assign no_data       = out_nodata_r;

endmodule

`default_nettype wire

@@ src/depth_layer_velocity_interpolator_top.sv @@
// Load request: writes the table entry, no result; the next request is taken the cycle after.
// Query: with no layers the result goes straight to the output register; at an end of
// the table the end entry's velocity is returned, else the bracket is found by the
// one-entry-per-cycle table walk and each axis then goes through the shared
// multiply and 16-step divider; one request in flight at a time.
// Reset (rst_n low, synchronous) clears the layer count and control; table contents stay.
`default_nettype none

module depth_layer_velocity_interpolator_top import dlvi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  dlvi_in_if.sink               in_ch,
  dlvi_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  dlvi_cmd_t          cmd;
  dlvi_sts_t          sts;
  logic [ADDR_W-1:0]  rd_addr;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic               wr_en;
  logic               in_ready;

  assign in_ch.ready = in_ready;

  // table write from load requests
  assign wr_en = in_ch.valid && in_ready && (in_ch.req_type == REQ_LOAD)
                 && (32'(in_ch.entry_slot) < MAX_LAYERS);
  assign wr_entry.depth = in_ch.entry_depth_cm;
  assign wr_entry.east  = in_ch.entry_vel_east;
  assign wr_entry.north = in_ch.entry_vel_north;
  assign wr_entry.up    = in_ch.entry_vel_up;

  // layer table
  dlvi_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_LAYERS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ADDR_W'(in_ch.entry_slot)),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  // controller
  dlvi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ready),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .sts         (sts),
    .cmd         (cmd),
    .rd_addr     (rd_addr)
  );

  // datapath
  dlvi_dp u_dp (
    .clk                  (clk),
    .cmd                  (cmd),
    .vertical_position_cm (in_ch.vertical_position_cm),
    .q                    (rd_entry),
    .sts                  (sts),
    .current_east         (out_ch.current_east),
    .current_north        (out_ch.current_north),
    .current_up           (out_ch.current_up),
    .depth_used_cm        (out_ch.depth_used_cm),
    .no_data              (out_ch.no_data)
  );

endmodule

`default_nettype wire

@@ src/dlvi_chk.sv @@
// port-level checker for the interpolator, bound to the top level
`default_nettype none
`include "depth_layer_velocity_interpolator_top_defines.svh"

module dlvi_chk import dlvi_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    in_req_type,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [VEL_W-1:0] out_east,
  input wire logic signed [VEL_W-1:0] out_north,
  input wire logic signed [VEL_W-1:0] out_up,
  input wire logic                    out_no_data
);

  // a result waiting for the sink stays offered
  `DLVI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // empty table gives zero velocities
  `DLVI_ASSERT_SAME(a_nodata_zero, out_valid && out_no_data, out_east == '0 && out_north == '0 && out_up == '0, "no_data result with nonzero velocity")

  // a load request never produces a result
  `DLVI_ASSERT_NEXT(a_load_silent, in_valid && in_ready && in_req_type == REQ_LOAD && !out_valid, !out_valid, "result appeared after a load request")

  // a query holds off the next request
  `DLVI_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_req_type == REQ_QUERY, !in_ready, "request taken while a query is in progress")

endmodule

bind depth_layer_velocity_interpolator_top dlvi_chk u_dlvi_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_east    (out_ch.current_east),
  .out_north   (out_ch.current_north),
  .out_up      (out_ch.current_up),
  .out_no_data (out_ch.no_data)
);

`default_nettype wire
